/* design/tgr_pkg.sv */
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, codes and small lookup functions for the glyph renderer.
// ----------------------------------------------------------------------------
package tgr_pkg;

  // item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_CURSOR = 2'd1;
  localparam logic [1:0] KIND_CHAR   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [2:0] REG_WRAP_ENABLE    = 3'd1;
  localparam logic [2:0] REG_FIRST_GLYPH    = 3'd2;
  localparam logic [2:0] REG_LAST_GLYPH     = 3'd3;
  localparam logic [2:0] REG_GLYPH_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_BYTES_PER_ROW  = 3'd5;
  localparam logic [2:0] REG_BITS_PER_PIXEL = 3'd6;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  localparam int COV_BITS = 64;

  typedef struct packed {
    logic [15:0] screen_width;
    logic        wrap_enable;
    logic [7:0]  first_glyph;
    logic [7:0]  last_glyph;
    logic [5:0]  glyph_height;
    logic [3:0]  bytes_per_row;
    logic [3:0]  bits_per_pixel;
  } cfg_t;

  // pixels taken from one font byte
  function automatic logic [3:0] pix_per_byte(input logic [3:0] bpp);
    logic [3:0] r;
    case (bpp)
      4'd1:    r = 4'd8;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd3;
      4'd4:    r = 4'd2;
      4'd5:    r = 4'd2;
      4'd6:    r = 4'd2;
      4'd7:    r = 4'd2;
      default: r = 4'd1;
    endcase
    return r;
  endfunction

  // coverage bit positions consumed by one font byte
  function automatic logic [4:0] bits_per_byte(input logic [3:0] bpp);
    logic [4:0] r;
    case (bpp)
      4'd1:    r = 5'd8;
      4'd2:    r = 5'd8;
      4'd3:    r = 5'd9;
      4'd4:    r = 5'd8;
      4'd5:    r = 5'd10;
      4'd6:    r = 5'd12;
      4'd7:    r = 5'd14;
      default: r = 5'(bpp);
    endcase
    return r;
  endfunction

endpackage

/* design/tgr_font_ram.sv */
// ----------------------------------------------------------------------------
// tgr_font_ram
// Font byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tgr_font_ram #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/tgr_seq.sv */
// ----------------------------------------------------------------------------
// tgr_seq
// Item sequencer: cursor, glyph lookup, row fetch and unpack, result register.
// ----------------------------------------------------------------------------
module tgr_seq #(
  parameter int AW           = 12,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_ROWS     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  tgr_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [11:0]        font_addr,
  input  logic [7:0]         font_byte,
  input  logic [7:0]         char_code,
  input  logic [15:0]        new_cursor_x,
  input  logic [15:0]        new_cursor_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        row_x,
  output logic [15:0]        row_y,
  output logic [7:0]         row_width,
  output logic [63:0]        row_coverage,
  output logic               row_last,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [7:0]         mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic [7:0]         mem_rdata
);

  localparam int RW = $clog2(MAX_ROWS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FOLD  = 7'b0000010,
    S_ADDR  = 7'b0000100,
    S_WIDTH = 7'b0001000,
    S_ROW   = 7'b0010000,
    S_BYTE  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t        state;
  logic [15:0]   cursor_x;
  logic [15:0]   cursor_y;
  logic [7:0]    code;
  logic [7:0]    glyph_off;
  logic [9:0]    stride;
  logic [AW-1:0] rowbase;
  logic [7:0]    width;
  logic [RW-1:0] rows;
  logic [RW-1:0] line;
  logic [3:0]    fetched;
  logic [8:0]    pix;
  logic [6:0]    bitpos;
  logic [63:0]   cov;

  logic          in_acc;
  logic [7:0]    c_fold;
  logic [18:0]   start_full;
  logic [AW-1:0] row_rd_addr;
  logic [3:0]    ppb;
  logic [4:0]    step;
  logic [8:0]    pix_next;
  logic [6:0]    bitpos_next;
  logic [8:0]    rem;
  logic [5:0]    nb_full;
  logic [7:0]    byte_mask;
  logic [63:0]   cov_next;
  logic          row_done;
  logic          wrap_hit;
  logic [15:0]   wrap_x;
  logic [15:0]   wrap_y;
  logic [RW-1:0] rows_cfg;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign mem_we    = in_acc && (kind == tgr_pkg::KIND_LOAD);
  assign mem_waddr = AW'(font_addr);
  assign mem_wdata = font_byte;

  // case folding
  always_comb begin
    c_fold = code;
    if (c_fold < cfg.first_glyph && c_fold >= tgr_pkg::CH_UPPER_A &&
        c_fold <= tgr_pkg::CH_UPPER_Z) begin
      c_fold = c_fold + tgr_pkg::CASE_DELTA;
    end
    if (c_fold > cfg.last_glyph && c_fold >= tgr_pkg::CH_LOWER_A &&
        c_fold <= tgr_pkg::CH_LOWER_Z) begin
      c_fold = c_fold - tgr_pkg::CASE_DELTA;
    end
  end

  assign start_full = 19'(HEADER_BYTES) + 19'(glyph_off) * 19'(stride);

  // bytes of a row are walked from the last one backwards
  assign row_rd_addr = rowbase + AW'(cfg.bytes_per_row) - AW'(fetched) - AW'(1);

  always_comb begin
    if (state == S_ADDR) begin
      mem_raddr = AW'(start_full);
    end else begin
      mem_raddr = row_rd_addr;
    end
  end

  // unpack one font byte into the coverage word
  assign ppb         = tgr_pkg::pix_per_byte(cfg.bits_per_pixel);
  assign step        = tgr_pkg::bits_per_byte(cfg.bits_per_pixel);
  assign pix_next    = pix + 9'(ppb);
  assign bitpos_next = bitpos + 7'(step);
  assign rem         = {1'b0, width} - pix;
  assign nb_full     = 6'(rem[2:0]) * 6'(cfg.bits_per_pixel[2:0]);

  always_comb begin
    if (rem >= 9'(ppb)) begin
      byte_mask = 8'hff;
    end else begin
      byte_mask = (8'd1 << nb_full[3:0]) - 8'd1;
    end
  end

  assign cov_next = cov | (64'(mem_rdata & byte_mask) << bitpos[5:0]);
  assign row_done = (pix_next >= {1'b0, width}) ||
                    (bitpos_next >= 7'(tgr_pkg::COV_BITS));

  // wrap decision, taken on the fresh width byte
  assign wrap_hit = cfg.wrap_enable &&
                    ({1'b0, cursor_x} + 17'(mem_rdata) > {1'b0, cfg.screen_width});
  assign wrap_x   = wrap_hit ? 16'd0 : cursor_x;
  assign wrap_y   = wrap_hit ? cursor_y + 16'(cfg.glyph_height) : cursor_y;

  always_comb begin
    if (32'(cfg.glyph_height) < MAX_ROWS) begin
      rows_cfg = RW'(cfg.glyph_height);
    end else begin
      rows_cfg = RW'(MAX_ROWS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor_x  <= 16'd0;
      cursor_y  <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            code <= char_code;
            if (kind == tgr_pkg::KIND_CURSOR) begin
              cursor_x <= new_cursor_x;
              cursor_y <= new_cursor_y;
            end else if (kind == tgr_pkg::KIND_CHAR) begin
              state <= S_FOLD;
            end
          end
        end
        S_FOLD: begin
          glyph_off <= c_fold - cfg.first_glyph;
          stride    <= 10'(cfg.glyph_height) * 10'(cfg.bytes_per_row) + 10'd1;
          if (code == tgr_pkg::CH_NEWLINE) begin
            cursor_y <= cursor_y + 16'(cfg.glyph_height);
            cursor_x <= 16'd0;
            state    <= S_IDLE;
          end else if (code == tgr_pkg::CH_RETURN ||
                       c_fold < cfg.first_glyph || c_fold > cfg.last_glyph) begin
            state <= S_IDLE;
          end else begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          rowbase <= AW'(start_full + 19'd1);
          state   <= S_WIDTH;
        end
        S_WIDTH: begin
          width    <= mem_rdata;
          rows     <= rows_cfg;
          line     <= '0;
          fetched  <= 4'd0;
          cursor_y <= wrap_y;
          if (rows_cfg == '0) begin
            cursor_x <= wrap_x + 16'(mem_rdata);
            state    <= S_IDLE;
          end else begin
            cursor_x <= wrap_x;
            state    <= S_ROW;
          end
        end
        S_ROW: begin
          cov    <= 64'd0;
          pix    <= 9'd0;
          bitpos <= 7'd0;
          if (width == 8'd0 || cfg.bits_per_pixel == 4'd0) begin
            state <= S_EMIT;
          end else begin
            fetched <= 4'd1;
            state   <= S_BYTE;
          end
        end
        S_BYTE: begin
          cov    <= cov_next;
          pix    <= pix_next;
          bitpos <= bitpos_next;
          if (row_done) begin
            state <= S_EMIT;
          end else begin
            fetched <= fetched + 4'd1;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            row_x        <= cursor_x;
            row_y        <= cursor_y + 16'(line);
            row_width    <= width;
            row_coverage <= cov;
            row_last     <= (line + RW'(1) == rows);
            if (line + RW'(1) == rows) begin
              cursor_x <= cursor_x + 16'(width);
              state    <= S_IDLE;
            end else begin
              line    <= line + RW'(1);
              rowbase <= rowbase + AW'(cfg.bytes_per_row);
              fetched <= 4'd0;
              state   <= S_ROW;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/text_glyph_renderer.sv */
// ----------------------------------------------------------------------------
// text_glyph_renderer
// Bitmap font character generator with a text cursor and line wrap.
// ----------------------------------------------------------------------------
// load and set-cursor beats finish in the idle state; newline, return and unknown
// codes pass through the fold state; a drawn glyph goes fold, address, width, then
// per row a row state, a byte state per font byte and an emit state that waits
// on out_ready; rows = min(height, MAX_ROWS), bytes = min(ceil(width / pixels per
// byte), ceil(64 / bits per byte)). one character is in flight at a time
// reset restores the register defaults and homes the cursor; the font memory
// is not cleared and holds nothing valid until loaded
module text_glyph_renderer #(
  parameter int FONT_BYTES   = 4096,
  parameter int HEADER_BYTES = 4,
  parameter int MAX_ROWS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [11:0] font_addr,
  input  logic [7:0]  font_byte,
  input  logic [7:0]  char_code,
  input  logic [15:0] new_cursor_x,
  input  logic [15:0] new_cursor_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] row_x,
  output logic [15:0] row_y,
  output logic [7:0]  row_width,
  output logic [63:0] row_coverage,
  output logic        row_last
);

  // FONT_BYTES must be a power of two; the block itself does not enforce it
  localparam int AW = $clog2(FONT_BYTES);

  tgr_pkg::cfg_t cfg;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width   <= 16'd320;
      cfg.wrap_enable    <= 1'b1;
      cfg.first_glyph    <= 8'd32;
      cfg.last_glyph     <= 8'd126;
      cfg.glyph_height   <= 6'd16;
      cfg.bytes_per_row  <= 4'd2;
      cfg.bits_per_pixel <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        tgr_pkg::REG_SCREEN_WIDTH:   cfg.screen_width   <= cfg_data;
        tgr_pkg::REG_WRAP_ENABLE:    cfg.wrap_enable    <= cfg_data[0];
        tgr_pkg::REG_FIRST_GLYPH:    cfg.first_glyph    <= cfg_data[7:0];
        tgr_pkg::REG_LAST_GLYPH:     cfg.last_glyph     <= cfg_data[7:0];
        tgr_pkg::REG_GLYPH_HEIGHT:   cfg.glyph_height   <= cfg_data[5:0];
        tgr_pkg::REG_BYTES_PER_ROW:  cfg.bytes_per_row  <= cfg_data[3:0];
        tgr_pkg::REG_BITS_PER_PIXEL: cfg.bits_per_pixel <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  tgr_font_ram #(
    .AW(AW)
  ) u_font_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tgr_seq #(
    .AW           (AW),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_ROWS     (MAX_ROWS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .font_addr    (font_addr),
    .font_byte    (font_byte),
    .char_code    (char_code),
    .new_cursor_x (new_cursor_x),
    .new_cursor_y (new_cursor_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_x        (row_x),
    .row_y        (row_y),
    .row_width    (row_width),
    .row_coverage (row_coverage),
    .row_last     (row_last),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

endmodule
